>>> src/rrts_pkg.sv
package rrts_pkg;

    localparam int OP_W         = 2;
    localparam int DURATION_W   = 32;
    localparam int SLOT_FIELD_W = 4;
    localparam int SLICE_W      = 16;
    localparam int TICK_W       = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SLEEP = 2'd1;
    localparam logic [OP_W-1:0] OP_YIELD = 2'd2;
    localparam logic [OP_W-1:0] OP_ADMIT = 2'd3;

    // slot table codes
    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_READY    = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_SLEEPING = 2'd3;

    localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = 16'd30;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [DURATION_W-1:0]   duration;
        logic [SLOT_FIELD_W-1:0] task_slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] running_slot;
        logic                    running_valid;
        logic                    switched;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic tick_upd;
        logic wake_start;
        logic sleep_wr;
        logic search_start;
        logic admit_rd;
        logic admit_wr;
        logic commit_a;
        logic commit_b;
        logic rsp_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            resched;
        logic            scan_active;
        logic            scan_done;
        logic            rsp_free;
    } dp_status_t;

endpackage

>>> src/rrts_ctrl.sv
module rrts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  rrts_pkg::dp_status_t status,
    output rrts_pkg::dp_cmd_t    cmd
);
    import rrts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WAKE,
        S_SEARCH,
        S_COMMIT,
        S_ADMIT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.operation)
                    OP_TICK:
                    begin
                        cmd.tick_upd   = 1'b1;
                        cmd.wake_start = 1'b1;
                        state_next     = S_WAKE;
                    end
                    OP_SLEEP:
                    begin
                        cmd.sleep_wr     = 1'b1;
                        cmd.search_start = 1'b1;
                        state_next       = S_SEARCH;
                    end
                    OP_YIELD:
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = S_SEARCH;
                    end
                    OP_ADMIT:
                    begin
                        cmd.admit_rd = 1'b1;
                        state_next   = S_ADMIT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_WAKE:
            begin
                if (status.scan_done)
                begin
                    if (status.resched)
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SEARCH:
            begin
                if (status.scan_done)
                begin
                    cmd.commit_a = 1'b1;
                    state_next   = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit_b = 1'b1;
                state_next   = S_RESULT;
            end
            S_ADMIT:
            begin
                cmd.admit_wr = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                // wait for the result register to be free
                if (status.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/rrts_dp.sv
module rrts_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rrts_pkg::dp_cmd_t                   cmd,
    output rrts_pkg::dp_status_t                status,
    input  rrts_pkg::req_t                      req,
    input  logic                                cfg_wr_en,
    input  logic [rrts_pkg::SLICE_W-1:0]        cfg_wr_data,
    input  logic                                rsp_stall,
    output logic                                rsp_valid,
    output rrts_pkg::rsp_t                      rsp
);
    import rrts_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int ADM_W  = SLOT_W + SLOT_FIELD_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0]  SCAN_LEN = CNT_W'(MAX_TASKS);
    localparam logic [ADM_W-1:0]  TASKS_WIDE = ADM_W'(MAX_TASKS);

    // slot table and wake times
    logic [1:0]        st_mem   [MAX_TASKS];
    logic [TICK_W-1:0] wake_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] st_vld_reg;
    logic [1:0]        st_rd_reg;
    logic              vld_rd_reg;
    logic [TICK_W-1:0] wake_rd_reg;

    req_t              req_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [SLICE_W-1:0] slice_reg;
    logic [SLICE_W-1:0] time_slice_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              cur_valid_reg;
    logic              resched_reg;
    logic              switched_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    // scanner
    logic              active_reg;
    logic              search_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic              pend_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SLOT_W-1:0] pend_idx_reg;
    logic [SLOT_W-1:0] cand_reg;

    logic [ADM_W-1:0]  adm_wide;
    logic              adm_ok;
    logic [SLOT_W-1:0] adm_idx;
    logic [ADM_W-1:0]  cur_wide;
    logic              rd_issue;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [1:0]        st_eff;
    logic              is_cur;
    logic              sleep_op;
    logic              cand_ready;
    logic              wake_hit;
    logic              found_hit;
    logic              scan_done;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [1:0]        wr_data;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] wake_sum;
    logic [SLICE_W-1:0] slice_inc;
    logic              wrap;
    logic              rsp_free;

    function automatic logic [SLOT_W-1:0] step_idx(input logic [SLOT_W-1:0] x);
        return (x == LAST_IDX) ? '0 : SLOT_W'(x + 1'b1);
    endfunction

    assign adm_wide = ADM_W'(req_reg.task_slot);
    assign adm_ok   = (adm_wide < TASKS_WIDE);
    assign adm_idx  = adm_wide[SLOT_W-1:0];
    assign cur_wide = ADM_W'(cur_reg);

    assign rd_issue = active_reg && (issue_reg != SCAN_LEN) && !(search_reg && found_reg);
    assign rd_en    = rd_issue || cmd.admit_rd;
    assign rd_addr  = cmd.admit_rd ? adm_idx : rd_idx_reg;

    // an entry never written reads as empty
    assign st_eff   = vld_rd_reg ? st_rd_reg : ST_EMPTY;
    assign sleep_op = (req_reg.operation == OP_SLEEP);
    assign is_cur   = cur_valid_reg && (pend_idx_reg == cur_reg);
    // the running task counts as ready, unless it is going to sleep
    assign cand_ready = is_cur ? !sleep_op : (st_eff == ST_READY);

    assign wake_hit  = active_reg && !search_reg && pend_reg &&
                       (st_eff == ST_SLEEPING) && (wake_rd_reg <= tick_reg);
    assign found_hit = active_reg && search_reg && pend_reg && !found_reg && cand_ready;
    assign scan_done = active_reg && !rd_issue && !pend_reg;

    assign tick_inc  = tick_reg + 64'd1;
    assign wake_sum  = tick_reg + TICK_W'(req_reg.duration);
    assign slice_inc = slice_reg + 16'd1;
    assign wrap      = (slice_inc >= time_slice_reg);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_idx_reg;
        wr_data = ST_READY;
        if (wake_hit)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.admit_wr)
        begin
            wr_en   = adm_ok && (st_eff == ST_EMPTY);
            wr_addr = adm_idx;
        end
        else if (cmd.commit_a)
        begin
            // demote or park the old task unless it keeps running
            wr_en   = cur_valid_reg && (!found_reg || (cand_reg != cur_reg));
            wr_addr = cur_reg;
            wr_data = sleep_op ? ST_SLEEPING : ST_READY;
        end
        else if (cmd.commit_b)
        begin
            wr_en   = found_reg && !(cur_valid_reg && (cand_reg == cur_reg));
            wr_addr = cand_reg;
            wr_data = ST_RUNNING;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            st_mem[wr_addr] <= wr_data;
        end
        if (cmd.sleep_wr && cur_valid_reg)
        begin
            wake_mem[cur_reg] <= wake_sum;
        end
        if (rd_en)
        begin
            st_rd_reg   <= st_mem[rd_addr];
            wake_rd_reg <= wake_mem[rd_addr];
            vld_rd_reg  <= st_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.wake_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.search_start)
        begin
            rd_idx_reg <= step_idx(cur_reg);
        end
        else if (rd_issue)
        begin
            rd_idx_reg <= step_idx(rd_idx_reg);
        end
        if (rd_issue)
        begin
            pend_idx_reg <= rd_idx_reg;
        end
        if (found_hit)
        begin
            cand_reg <= pend_idx_reg;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.running_slot  <= cur_valid_reg ? cur_wide[SLOT_FIELD_W-1:0] : '0;
            rsp_reg.running_valid <= cur_valid_reg;
            rsp_reg.switched      <= switched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg     <= '0;
            tick_reg       <= '0;
            slice_reg      <= '0;
            time_slice_reg <= TIME_SLICE_RESET;
            cur_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            resched_reg    <= 1'b0;
            switched_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            active_reg     <= 1'b0;
            search_reg     <= 1'b0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                st_vld_reg[wr_addr] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                time_slice_reg <= cfg_wr_data;
            end
            if (cmd.tick_upd)
            begin
                tick_reg    <= tick_inc;
                slice_reg   <= wrap ? '0 : slice_inc;
                resched_reg <= wrap || !cur_valid_reg;
            end
            if (cmd.load)
            begin
                switched_reg <= 1'b0;
            end
            if (cmd.commit_b)
            begin
                cur_reg       <= found_reg ? cand_reg : cur_reg;
                cur_valid_reg <= found_reg;
                switched_reg  <= 1'b1;
            end

            pend_reg <= rd_issue;
            if (rd_issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (found_hit)
            begin
                found_reg <= 1'b1;
            end
            if (scan_done)
            begin
                active_reg <= 1'b0;
            end
            if (cmd.wake_start || cmd.search_start)
            begin
                active_reg <= 1'b1;
                search_reg <= cmd.search_start;
                issue_reg  <= '0;
                found_reg  <= 1'b0;
            end

            if (cmd.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.operation   = req_reg.operation;
    assign status.resched     = resched_reg;
    assign status.scan_active = active_reg;
    assign status.scan_done   = scan_done;
    assign status.rsp_free    = rsp_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/round_robin_tick_scheduler.sv
// One item at a time, from accept until the result register is loaded:
//   admit checks its slot, yield or sleep searches, a tick wakes and searches on a reschedule.
// The slot scans (wake compare and ready search) visit one slot per cycle through the
// single read port of the slot table; the next item is taken the cycle after the load.
// Reset clears the slot table through per-slot valid bits at once (no clearing pass),
// zeroes tick and slice counts, leaves no task running and sets time_slice to 30.
module round_robin_tick_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  rrts_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output rrts_pkg::rsp_t               rsp,
    input  logic                         cfg_wr_en,
    input  logic [rrts_pkg::SLICE_W-1:0] cfg_wr_data
);
    import rrts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

    // idle result carries slot zero
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.running_valid |-> rsp.running_slot == '0)
        else $error("idle result with nonzero slot");

    // an accepted item holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted back to back");

    // no slot scan may run while items are being accepted
    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !status.scan_active)
        else $error("slot scan active while idle");

endmodule
